FILE: hdl/pcmf_pkg.sv
// ============================================================================
// pcmf_pkg - shared types and constants for the PCM to float converter
// Sample format codes and the inter-stage record.
// ============================================================================
`default_nettype none
package pcmf_pkg;

  localparam int unsigned FmtW = 3;
  localparam logic [FmtW-1:0] FmtReset = 3'd1;

  typedef enum logic [FmtW-1:0] {
    FMT_U8  = 3'd0,
    FMT_S16 = 3'd1,
    FMT_S24 = 3'd2,
    FMT_S32 = 3'd3,
    FMT_F32 = 3'd4,
    FMT_F64 = 3'd5,
    FMT_R6  = 3'd6,
    FMT_R7  = 3'd7
  } fmt_e;

  // Stage 1 -> stage 2 record: unpacked operand ready for normalization.
  typedef struct packed {
    logic        pass;     // result fixed, in bits
    logic [31:0] bits;
    logic        is_dbl;   // double path
    logic        neg;
    logic [31:0] mag;      // integer magnitude (<= 2^31)
    logic [4:0]  scale;
    logic [10:0] dexp;
    logic [52:0] dman;     // double mantissa with hidden bit
    logic        last;
  } s1_t;

  // Stage 2 -> stage 3 record: shifted value before rounding.
  typedef struct packed {
    logic        pass;
    logic [31:0] bits;
    logic        neg;
    logic [8:0]  fe;       // biased exponent, unsigned
    logic [25:0] sig;      // 24 kept bits, guard, sticky
    logic        sub;      // double subnormal path: no hidden bit
    logic        last;
  } s2_t;

endpackage
`default_nettype wire

FILE: hdl/pcmf_unpack.sv
// ============================================================================
// pcmf_unpack - stage 1
// Picks the sample bits per format, forms sign and magnitude, spots specials.
// ============================================================================
`default_nettype none
module pcmf_unpack (
  input  wire logic [63:0]          raw_i,
  input  wire logic                 last_i,
  input  wire pcmf_pkg::fmt_e       fmt_i,
  output pcmf_pkg::s1_t             s1_o
);
  logic [10:0] ex;
  logic [51:0] fr;
  logic [31:0] v;
  always_comb begin
    ex = raw_i[62:52];
    fr = raw_i[51:0];
    v  = 32'd0;
    s1_o = '0;
    s1_o.last = last_i;
    s1_o.dexp = ex;
    s1_o.dman = {1'b1, fr};
    case (fmt_i)
      pcmf_pkg::FMT_U8: begin
        s1_o.neg   = ~raw_i[7];
        s1_o.mag   = raw_i[7] ? {25'd0, raw_i[6:0]} : 32'd128 - {24'd0, raw_i[7:0]};
        s1_o.scale = 5'd7;
      end
      pcmf_pkg::FMT_S16: begin
        v = {{16{raw_i[15]}}, raw_i[15:0]};
        s1_o.neg = raw_i[15];
        s1_o.mag = raw_i[15] ? 32'd0 - v : v;
        s1_o.scale = 5'd15;
      end
      pcmf_pkg::FMT_S24: begin
        v = {{8{raw_i[23]}}, raw_i[23:0]};
        s1_o.neg = raw_i[23];
        s1_o.mag = raw_i[23] ? 32'd0 - v : v;
        s1_o.scale = 5'd23;
      end
      pcmf_pkg::FMT_S32: begin
        s1_o.neg = raw_i[31];
        s1_o.mag = raw_i[31] ? 32'd0 - raw_i[31:0] : raw_i[31:0];
        s1_o.scale = 5'd31;
      end
      pcmf_pkg::FMT_F32: begin
        s1_o.pass = 1'b1;
        s1_o.bits = raw_i[31:0];
      end
      pcmf_pkg::FMT_F64: begin
        s1_o.is_dbl = 1'b1;
        s1_o.neg    = raw_i[63];
        if (ex == 11'h7FF) begin
          s1_o.pass = 1'b1;
          s1_o.bits = (fr == 52'd0) ? {raw_i[63], 8'hFF, 23'd0}
                                    : {raw_i[63], 8'hFF, 1'b1, fr[50:29]};
        end else if (ex == 11'd0) begin
          s1_o.pass = 1'b1;
          s1_o.bits = {raw_i[63], 31'd0};
        end
      end
      default: begin
        s1_o.pass = 1'b1;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/pcmf_norm.sv
// ============================================================================
// pcmf_norm - stage 2
// Leading-one search and alignment to a 24-bit significand plus guard/sticky.
// ============================================================================
`default_nettype none
module pcmf_norm (
  input  wire pcmf_pkg::s1_t s1_i,
  output pcmf_pkg::s2_t s2_o
);
  logic [4:0]  p;
  logic [63:0] w;
  logic [6:0]  sh;
  logic signed [11:0] fe;
  logic [55:0] shd;
  logic        stk;
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (s1_i.mag[i]) p = 5'(i);
    end
    s2_o = '0;
    s2_o.pass = s1_i.pass;
    s2_o.bits = s1_i.bits;
    s2_o.neg  = s1_i.neg;
    s2_o.last = s1_i.last;
    w = '0; sh = '0; fe = '0; shd = '0; stk = 1'b0;
    if (s1_i.is_dbl) begin
      fe = $signed({1'b0, s1_i.dexp}) - 12'sd896;
      if (fe >= 12'sd1) begin
        // keep 24 bits, guard at bit 28, sticky below
        s2_o.sig = {s1_i.dman[52:28], |s1_i.dman[27:0]};
        // anything at or above 255 overflows; saturate to fit the field
        s2_o.fe  = (fe > 12'sd255) ? 9'd255 : 9'(fe);
      end else begin
        // subnormal: result = m >> (30 - fe); shift by one less keeps guard at bit 0
        if (fe <= -12'sd24) begin
          s2_o.sig = '0;
        end else begin
          sh  = 7'(12'sd29 - fe);
          shd = {3'd0, s1_i.dman} >> sh;
          for (int j = 0; j < 53; j++) begin
            if (j < int'(sh) && s1_i.dman[j]) stk = 1'b1;
          end
          s2_o.sig = {shd[24:0], stk};
        end
        s2_o.sub = 1'b1;
        s2_o.fe  = 9'd0;
      end
    end else if (!s1_i.pass) begin
      if (s1_i.mag == 32'd0) begin
        s2_o.pass = 1'b1;
        s2_o.bits = 32'd0;
      end else begin
        w = {32'd0, s1_i.mag} << (6'd32 - {1'b0, p});
        // w[32] = leading one, next 23 kept, then guard and sticky
        s2_o.sig = {w[32:8], |w[7:0]};
        s2_o.fe  = 9'({4'd0, p} - {4'd0, s1_i.scale} + 9'd127);
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/pcmf_round.sv
// ============================================================================
// pcmf_round - stage 3
// Nearest-even rounding, carry into exponent, overflow to infinity, packing.
// ============================================================================
`default_nettype none
module pcmf_round (
  input  wire pcmf_pkg::s2_t s2_i,
  output logic [31:0]   bits_o
);
  logic        g, s, lsb, inc;
  logic [24:0] r;
  logic [8:0]  e;
  always_comb begin
    g   = s2_i.sig[1];
    s   = s2_i.sig[0];
    lsb = s2_i.sig[2];
    inc = g & (s | lsb);
    r   = {1'b0, s2_i.sig[25:2]} + {24'd0, inc};
    e   = s2_i.fe;
    if (s2_i.pass) begin
      bits_o = s2_i.bits;
    end else if (s2_i.sub) begin
      // carry into bit 23 naturally yields the smallest normal
      bits_o = {s2_i.neg, 8'd0, 23'd0} + {7'd0, r};
    end else begin
      if (r[24]) e = e + 9'd1;
      if (e >= 9'd255) begin
        bits_o = {s2_i.neg, 8'hFF, 23'd0};
      end else begin
        bits_o = {s2_i.neg, e[7:0], (r[24] ? r[23:1] : r[22:0])};
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/pcm_sample_to_float_converter_top.sv
// ============================================================================
// pcm_sample_to_float_converter_top - raw PCM sample to binary32
// Three-stage pipeline: unpack, normalize, round/pack; output register.
// ============================================================================
//  channel   dir  handshake             payload
//  sample    in   s_valid_i/s_ready_o   raw_sample_i[63:0], last_in_i
//  float     out  m_valid_o/m_ready_i   float_bits_o[31:0], last_out_o
//  config    in   cfg_we_i              cfg_data_i[2:0] (sample_format)
//
// One transaction per clock sustained while m_ready_i is high; a sample
// passes the unpack, normalize and round register stages in that order
// before it is offered on the float channel.
// Reset clears all valid bits and loads format int16.
// A stall freezes every full stage with no empty stage ahead; bubbles are filled, so ready
// stays high while any stage ahead is empty.
`default_nettype none
module pcm_sample_to_float_converter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_data_i,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  wire logic [63:0] raw_sample_i,
  input  wire logic        last_in_i,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [31:0]      float_bits_o,
  output logic             last_out_o
);
  pcmf_pkg::fmt_e fmt_q;
  pcmf_pkg::s1_t  s1_d, s1_q;
  pcmf_pkg::s2_t  s2_d, s2_q;
  logic [31:0]    bits_d, bits_q;
  logic           last_q;
  logic           v1_q, v2_q, v3_q;
  logic           en1, en2, en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fmt_q <= pcmf_pkg::fmt_e'(pcmf_pkg::FmtReset);
    else if (cfg_we_i) fmt_q <= pcmf_pkg::fmt_e'(cfg_data_i);
  end

  // stage advance when downstream slot is free or moving
  assign en3 = !v3_q || m_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_ready_o = en1;

  pcmf_unpack u_unpack (.raw_i(raw_sample_i), .last_i(last_in_i), .fmt_i(fmt_q),
                        .s1_o(s1_d));
  pcmf_norm   u_norm   (.s1_i(s1_q), .s2_o(s2_d));
  pcmf_round  u_round  (.s2_i(s2_q), .bits_o(bits_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) begin
      bits_q <= bits_d;
      last_q <= s2_q.last;
    end
  end

  assign m_valid_o    = v3_q;
  assign float_bits_o = bits_q;
  assign last_out_o   = last_q;
endmodule
`default_nettype wire
